// ===== rtl/csa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants for the chunked stack slot allocator
// Row layout of the occupancy store, register indexes, operation codes,
// reset values and a small priority encoder.
// ----------------------------------------------------------------------------
package csa_pkg;

    // Occupancy is stored as rows of sixteen slot bits.
    localparam int ROW_BITS = 16;
    localparam int ROW_LOG  = 4;
    typedef logic [ROW_BITS-1:0] t_row;
    localparam t_row ROW_ONES = '1;

    // Field and register widths.
    localparam int REG_W      = 13;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SLOTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'b1;

    // Request kinds.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Reset values of the registers.
    localparam logic [REG_W-1:0] CHUNK_RESET = 13'd64;
    localparam logic [REG_W-1:0] CAP_RESET   = 13'd4096;

    // Default sizes of the pool.
    localparam int DEF_MAX_SLOTS = 4096;
    localparam int DEF_MAX_RUN   = 64;

    // Position of the highest set bit of a row; zero for an empty row.
    function automatic logic [ROW_LOG-1:0] msb_pos(input t_row v);
        logic [ROW_LOG-1:0] pos;
        pos = '0;
        for (int b = 0; b < ROW_BITS; b++) begin
            if (v[b]) begin
                pos = ROW_LOG'(b);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/csa_occ_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_occ_ram: occupancy store
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module csa_occ_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/csa_rem_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_rem_div: remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module csa_rem_div #(
    parameter int DW = 13,
    parameter int TW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [TW-1:0] i_divisor,
    output logic          o_done,
    output logic [TW-1:0] o_rem
);

    localparam int CNW = $clog2(DW + 1);

    logic [DW-1:0]  r_dvd;
    logic [TW-1:0]  r_div;
    logic [TW-1:0]  r_rem;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [TW:0]    n_shift;
    logic [TW:0]    n_diff;

    always_comb begin
        n_shift = {r_rem, r_dvd[DW-1]};
        n_diff  = n_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CNW'(DW);
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                // The partial remainder stays below the divisor, so it fits TW bits.
                if (n_shift >= {1'b0, r_div}) begin
                    r_rem <= n_diff[TW-1:0];
                end else begin
                    r_rem <= n_shift[TW-1:0];
                end
                r_dvd  <= r_dvd << 1;
                r_cnt  <= r_cnt - CNW'(1);
                r_done <= (r_cnt == CNW'(1));
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/chunked_stack_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_stack_slot_allocator: stack-like slot allocator over chunked slots
// Keeps one occupancy bit per slot in a row memory and a top count. Grants
// runs that never cross a chunk, frees single slots and walks top down.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: action; tdata: count, free_index
//  m_axis    out        tdata: start_index, overflow, slot_conflict, top_count
//  cfg       in         i_cfg_idx 0 chunk_slots, 1 capacity; no read-back
//
// An allocate runs the bit-serial remainder unit that finds the chunk offset,
// then reads and writes back each occupancy row that the run touches. A free
// reads and writes back the row of the freed slot, then walks rows down while
// top moves down. After reset a clearing pass of one row per cycle runs before
// the first word is taken. A result waits in the output register; the next
// word is taken once the current one has loaded its result there.
module chunked_stack_slot_allocator #(
    parameter int MAX_SLOTS = csa_pkg::DEF_MAX_SLOTS,
    parameter int MAX_RUN   = csa_pkg::DEF_MAX_RUN
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: count [6:0], free_index [18:7], zero fill
    input  logic [csa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: action [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: start_index [11:0], overflow [12], slot_conflict [13],
    //        top_count [26:14], zero fill
    output logic [csa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [csa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [csa_pkg::REG_W-1:0]         i_cfg_data
);

    localparam int ROW_BITS = csa_pkg::ROW_BITS;
    localparam int ROW_LOG  = csa_pkg::ROW_LOG;
    localparam int NROWS    = (MAX_SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int AW       = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int TW       = $clog2(MAX_SLOTS + 1);
    localparam int DW       = $clog2(MAX_SLOTS + MAX_RUN);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DIV, S_PLACE, S_RMW, S_FREE, S_WALK, S_DONE
    } t_state;

    t_state                        r_state;
    logic [csa_pkg::REG_W-1:0]     r_chunk;
    logic [csa_pkg::REG_W-1:0]     r_cap;
    logic [TW-1:0]                 r_top;
    logic [TW-1:0]                 r_capx;
    logic                          r_action;
    logic [csa_pkg::CNT_W-1:0]     r_count;
    logic [csa_pkg::IDX_W-1:0]     r_fidx;
    logic [DW-1:0]                 r_dvd;
    logic [DW-1:0]                 r_start;
    logic [DW-1:0]                 r_last;
    logic [AW-1:0]                 r_row;
    logic                          r_ovf;
    logic                          r_conf;
    logic                          r_out_valid;
    logic [csa_pkg::IDX_W-1:0]     r_out_start;
    logic                          r_out_ovf;
    logic                          r_out_conf;
    logic [csa_pkg::REG_W-1:0]     r_out_top;

    logic                          in_action;
    logic [csa_pkg::CNT_W-1:0]     in_count;
    logic [csa_pkg::IDX_W-1:0]     in_fidx;
    logic                          accept;
    logic [TW-1:0]                 cs_eff;
    logic [TW-1:0]                 cap_eff;
    logic                          early_ovf;
    logic                          div_start;
    logic [DW-1:0]                 div_dividend;
    logic                          div_done;
    logic [TW-1:0]                 div_rem;
    logic [DW-1:0]                 n_start;
    logic [DW:0]                   run_end;
    logic [AW-1:0]                 start_row;
    logic [AW-1:0]                 last_row;
    csa_pkg::t_row                 run_mask;
    csa_pkg::t_row                 free_row;
    csa_pkg::t_row                 below_row;
    csa_pkg::t_row                 rd_data;
    logic                          fidx_is_top;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    csa_pkg::t_row                 wr_data;

    assign in_action = s_axis_tuser;
    assign in_count  = s_axis_tdata[csa_pkg::CNT_W-1:0];
    assign in_fidx   = s_axis_tdata[csa_pkg::CNT_W +: csa_pkg::IDX_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept    = s_axis_tvalid && s_axis_tready;

    // Effective register values: a chunk of zero acts as one, and both are
    // clamped to the pool size.
    always_comb begin
        if (r_chunk == '0) begin
            cs_eff = TW'(1);
        end else if (32'(r_chunk) > 32'(MAX_SLOTS)) begin
            cs_eff = TW'(MAX_SLOTS);
        end else begin
            cs_eff = TW'(r_chunk);
        end
        if (32'(r_cap) > 32'(MAX_SLOTS)) begin
            cap_eff = TW'(MAX_SLOTS);
        end else begin
            cap_eff = TW'(r_cap);
        end
    end

    always_comb begin
        early_ovf = (in_count == '0) || (32'(in_count) > 32'(MAX_RUN))
                    || (32'(in_count) > 32'(cs_eff));
        div_start    = accept && (in_action == csa_pkg::ACT_ALLOC) && !early_ovf;
        div_dividend = DW'(r_top) + DW'(in_count) - DW'(1);
    end

    // The run stays at top when top and the run's last slot share a chunk;
    // otherwise it moves to the start of the chunk holding the last slot.
    always_comb begin
        if (32'(div_rem) >= 32'(r_count) - 32'd1) begin
            n_start = DW'(r_top);
        end else begin
            n_start = r_dvd - DW'(div_rem);
        end
        run_end   = (DW + 1)'(r_start) + (DW + 1)'(r_count);
        start_row = AW'(r_start >> ROW_LOG);
        last_row  = AW'(r_last >> ROW_LOG);
    end

    always_comb begin
        logic [ROW_LOG-1:0] lo;
        logic [ROW_LOG-1:0] hi;
        logic [ROW_LOG-1:0] bitpos;
        lo     = (r_row == start_row) ? r_start[ROW_LOG-1:0] : '0;
        hi     = (r_row == last_row) ? r_last[ROW_LOG-1:0] : ROW_LOG'(ROW_BITS - 1);
        bitpos = r_fidx[ROW_LOG-1:0];
        run_mask  = (csa_pkg::ROW_ONES << lo)
                    & (csa_pkg::ROW_ONES >> (ROW_LOG'(ROW_BITS - 1) - hi));
        free_row  = rd_data & ~(csa_pkg::t_row'(1) << bitpos);
        below_row = free_row & ((csa_pkg::t_row'(1) << bitpos) - csa_pkg::t_row'(1));
        fidx_is_top = (r_top != '0) && (32'(r_fidx) + 32'd1 == 32'(r_top));
    end

    // Memory port control.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_row;
        wr_en   = 1'b0;
        wr_addr = r_row;
        wr_data = '0;
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_IDLE: begin
                rd_en   = accept && (in_action == csa_pkg::ACT_FREE);
                rd_addr = AW'(in_fidx >> ROW_LOG);
            end
            S_PLACE: begin
                rd_en   = !(32'(run_end) > 32'(r_capx));
                rd_addr = start_row;
            end
            S_RMW: begin
                wr_en   = 1'b1;
                wr_data = rd_data | run_mask;
                rd_en   = (r_row != last_row);
                rd_addr = r_row + AW'(1);
            end
            S_FREE: begin
                wr_en   = 1'b1;
                wr_data = free_row;
                rd_en   = fidx_is_top && (below_row == '0) && (r_row != '0);
                rd_addr = r_row - AW'(1);
            end
            S_WALK: begin
                rd_en   = (rd_data == '0) && (r_row != '0);
                rd_addr = r_row - AW'(1);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    csa_occ_ram #(
        .DEPTH (NROWS),
        .AW    (AW),
        .WIDTH (ROW_BITS)
    ) u_occ_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    csa_rem_div #(
        .DW (DW),
        .TW (TW)
    ) u_rem_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (cs_eff),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= csa_pkg::CHUNK_RESET;
            r_cap   <= csa_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                csa_pkg::REG_CHUNK_SLOTS: r_chunk <= i_cfg_data;
                csa_pkg::REG_CAPACITY:    r_cap   <= i_cfg_data;
                default:                  r_cap   <= r_cap;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
            r_ovf       <= 1'b0;
            r_conf      <= 1'b0;
        end else begin
            // In the result state the output register is handled below.
            if (m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_row <= r_row + AW'(1);
                    if (r_row == AW'(NROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_action <= in_action;
                        r_count  <= in_count;
                        r_fidx   <= in_fidx;
                        r_capx   <= cap_eff;
                        r_dvd    <= div_dividend;
                        r_ovf    <= (in_action == csa_pkg::ACT_ALLOC) && early_ovf;
                        r_conf   <= 1'b0;
                        r_row    <= AW'(in_fidx >> ROW_LOG);
                        if (in_action == csa_pkg::ACT_ALLOC) begin
                            if (early_ovf) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end else if (32'(in_fidx) < 32'(MAX_SLOTS)) begin
                            r_state <= S_FREE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_start <= n_start;
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    if (32'(run_end) > 32'(r_capx)) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_last  <= DW'(run_end - (DW + 1)'(1));
                        r_row   <= start_row;
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    if ((rd_data & run_mask) != '0) begin
                        r_conf <= 1'b1;
                    end
                    if (r_row == last_row) begin
                        r_top   <= TW'(r_last + DW'(1));
                        r_state <= S_DONE;
                    end else begin
                        r_row <= r_row + AW'(1);
                    end
                end
                S_FREE: begin
                    if (!fidx_is_top) begin
                        r_state <= S_DONE;
                    end else if (below_row != '0) begin
                        r_top   <= TW'({r_row, csa_pkg::msb_pos(below_row)}) + TW'(1);
                        r_state <= S_DONE;
                    end else if (r_row == '0) begin
                        r_top   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_row   <= r_row - AW'(1);
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (rd_data != '0) begin
                        r_top   <= TW'({r_row, csa_pkg::msb_pos(rd_data)}) + TW'(1);
                        r_state <= S_DONE;
                    end else if (r_row == '0) begin
                        r_top   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_row <= r_row - AW'(1);
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_ovf   <= r_ovf;
                        r_out_conf  <= r_conf;
                        r_out_top   <= csa_pkg::REG_W'(r_top);
                        if ((r_action == csa_pkg::ACT_ALLOC) && !r_ovf) begin
                            r_out_start <= csa_pkg::IDX_W'(r_start);
                        end else begin
                            r_out_start <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = csa_pkg::OUT_DATA_W'({r_out_top, r_out_conf, r_out_ovf,
                                                 r_out_start});

    // Top never passes the end of the pool.
    a_top_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_top) <= 32'(MAX_SLOTS))
        else $error("top count beyond the pool");

    // A granted run always ends within the effective capacity.
    a_grant_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_action == csa_pkg::ACT_ALLOC && !r_ovf)
        |-> 32'(r_top) <= 32'(r_capx))
        else $error("granted run ends beyond capacity");

    // The row sweep of an allocate never goes past the run's last row.
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |-> (r_row <= last_row))
        else $error("row sweep passed the end of the run");

endmodule
